FILE: design/bpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pkg: shared definitions for the button press classifier
// Button counts, command and event codes, register indexes and the event
// bundle that travels from the front end to the back end through the queue.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int TOUCH_BUTTONS = 3;
  localparam int PHYSICAL_PINS = 2;
  localparam int NBUTTONS      = TOUCH_BUTTONS + PHYSICAL_PINS;
  // Each button may cause up to two events per input: press, release or a
  // long press on a tick, followed by a short or long press on release.
  localparam int NEVENTS       = 2 * NBUTTONS;
  localparam int EV_W          = $clog2(NEVENTS);
  localparam int SLOT_W        = $clog2(NBUTTONS);
  localparam int QUEUE_DEPTH   = 2;

  localparam int TOUCH_W = 3;
  localparam int WHICH_W = 2;
  localparam int DUR_W   = 32;
  localparam int MS_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [TOUCH_W-1:0] TOUCH_ALL = 3'h7;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_TOUCH = 2'd1;
  localparam logic [1:0] CMD_PIN   = 2'd2;

  localparam logic [1:0] EV_PRESS   = 2'd0;
  localparam logic [1:0] EV_RELEASE = 2'd1;
  localparam logic [1:0] EV_SHORT   = 2'd2;
  localparam logic [1:0] EV_LONG    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIN0_ACT_LOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIN1_ACT_LOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOUCH_EN     = 3'd4;

  localparam logic [MS_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [MS_W-1:0] DEBOUNCE_RST   = 16'd50;

  // Event slot 2*i is the first event of button i, slot 2*i+1 the second.
  typedef struct packed {
    logic [NEVENTS-1:0]             pend;
    logic [NEVENTS-1:0][1:0]        kind;
    logic [NBUTTONS-1:0][DUR_W-1:0] dur;
    logic [TOUCH_W-1:0]             mask;
  } bpc_bundle_t;

endpackage
`default_nettype wire

FILE: design/bpc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_front: input acceptance and classification
// Holds the configuration and button state, takes one input transaction per
// cycle unless stalled and turns it into a bundle of events for the back end.
// ----------------------------------------------------------------------------
module bpc_front import bpc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,
  input  wire logic [1:0]            s_tuser,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  q_ready,
  output logic                       q_push,
  output bpc_bundle_t                q_data
);

  logic [MS_W-1:0]          long_ms;
  logic [MS_W-1:0]          debounce_lim;
  logic [PHYSICAL_PINS-1:0] act_low;
  logic                     touch_en;

  logic [DUR_W-1:0]         now_ms, now_ms_next;
  logic [DUR_W-1:0]         now_p1, now_p1_next;
  logic [TOUCH_W-1:0]       prev_mask, prev_mask_next;
  logic [PHYSICAL_PINS-1:0] pin_pressed, pin_pressed_next;
  logic [PHYSICAL_PINS-1:0] change_seen, change_seen_next;
  logic [NBUTTONS-1:0]      long_fired, long_fired_next;
  logic [NBUTTONS-1:0][DUR_W-1:0]      press_time, press_time_next;
  logic [PHYSICAL_PINS-1:0][DUR_W-1:0] last_change, last_change_next;

  logic [NBUTTONS-1:0][DUR_W-1:0]      rel_dur;
  logic [NBUTTONS-1:0][DUR_W-1:0]      tick_dur;
  logic [PHYSICAL_PINS-1:0][DUR_W-1:0] since_change;
  logic [NBUTTONS-1:0]                 held;

  logic [1:0]         cmd;
  logic [TOUCH_W-1:0] touch_bits;
  logic               read_ok;
  logic               pin_index;
  logic               pin_level;
  logic               accept;
  bpc_bundle_t        bund;

  assign cmd        = s_tuser;
  assign touch_bits = s_tdata[TOUCH_W-1:0];
  assign read_ok    = s_tdata[3];
  assign pin_index  = s_tdata[4];
  assign pin_level  = s_tdata[5];

  assign s_tready  = q_ready;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && q_ready;
  assign q_push    = accept && (bund.pend != '0);
  assign q_data    = bund;

  assign held = {pin_pressed, prev_mask[TOUCH_BUTTONS-1:0]};

  always_comb begin
    for (int i = 0; i < NBUTTONS; i++) begin
      rel_dur[i]  = now_ms - press_time[i];
      tick_dur[i] = now_p1 - press_time[i];
    end
    for (int p = 0; p < PHYSICAL_PINS; p++) begin
      since_change[p] = now_ms - last_change[p];
    end
  end

  always_comb begin
    logic act;
    act              = 1'b0;
    now_ms_next      = now_ms;
    now_p1_next      = now_p1;
    prev_mask_next   = prev_mask;
    pin_pressed_next = pin_pressed;
    change_seen_next = change_seen;
    long_fired_next  = long_fired;
    press_time_next  = press_time;
    last_change_next = last_change;
    bund             = '0;

    unique case (cmd)
      CMD_TICK: begin
        now_ms_next = now_p1;
        now_p1_next = now_p1 + 1'b1;
        bund.mask   = prev_mask;
        for (int i = 0; i < NBUTTONS; i++) begin
          if (held[i] && !long_fired[i] && tick_dur[i] >= DUR_W'(long_ms)) begin
            long_fired_next[i] = 1'b1;
            bund.pend[2*i]     = 1'b1;
            bund.kind[2*i]     = EV_LONG;
            bund.dur[i]        = tick_dur[i];
          end
        end
      end
      CMD_TOUCH: begin
        if (touch_en && read_ok) begin
          bund.mask      = touch_bits & TOUCH_ALL;
          prev_mask_next = touch_bits & TOUCH_ALL;
          for (int i = 0; i < TOUCH_BUTTONS; i++) begin
            if (touch_bits[i] && !prev_mask[i]) begin
              press_time_next[i] = now_ms;
              long_fired_next[i] = 1'b0;
              bund.pend[2*i]     = 1'b1;
              bund.kind[2*i]     = EV_PRESS;
            end else if (!touch_bits[i] && prev_mask[i]) begin
              bund.pend[2*i]     = 1'b1;
              bund.kind[2*i]     = EV_RELEASE;
              bund.dur[i]        = rel_dur[i];
              bund.pend[2*i+1]   = !long_fired[i];
              bund.kind[2*i+1]   = (rel_dur[i] >= DUR_W'(long_ms)) ? EV_LONG : EV_SHORT;
              press_time_next[i] = '0;
              long_fired_next[i] = 1'b0;
            end
          end
        end
      end
      CMD_PIN: begin
        for (int p = 0; p < PHYSICAL_PINS; p++) begin
          act = act_low[p] ? !pin_level : pin_level;
          if (pin_index == 1'(p)
              && !(change_seen[p] && since_change[p] < DUR_W'(debounce_lim))
              && act != pin_pressed[p]) begin
            last_change_next[p] = now_ms;
            change_seen_next[p] = 1'b1;
            pin_pressed_next[p] = act;
            bund.pend[2*(TOUCH_BUTTONS+p)] = 1'b1;
            if (act) begin
              press_time_next[TOUCH_BUTTONS+p] = now_ms;
              long_fired_next[TOUCH_BUTTONS+p] = 1'b0;
              bund.kind[2*(TOUCH_BUTTONS+p)]   = EV_PRESS;
            end else begin
              bund.kind[2*(TOUCH_BUTTONS+p)]     = EV_RELEASE;
              bund.dur[TOUCH_BUTTONS+p]          = rel_dur[TOUCH_BUTTONS+p];
              bund.pend[2*(TOUCH_BUTTONS+p)+1]   = !long_fired[TOUCH_BUTTONS+p];
              bund.kind[2*(TOUCH_BUTTONS+p)+1]   =
                (rel_dur[TOUCH_BUTTONS+p] >= DUR_W'(long_ms)) ? EV_LONG : EV_SHORT;
              press_time_next[TOUCH_BUTTONS+p]   = '0;
              long_fired_next[TOUCH_BUTTONS+p]   = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_ms      <= LONG_PRESS_RST;
      debounce_lim <= DEBOUNCE_RST;
      act_low      <= '1;
      touch_en     <= 1'b1;
      now_ms       <= '0;
      now_p1       <= DUR_W'(1);
      prev_mask    <= '0;
      pin_pressed  <= '0;
      change_seen  <= '0;
      long_fired   <= '0;
      press_time   <= '0;
      last_change  <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_LONG_PRESS:   long_ms      <= cfg_data;
          REG_DEBOUNCE:     debounce_lim <= cfg_data;
          REG_PIN0_ACT_LOW: act_low[0]   <= cfg_data[0];
          REG_PIN1_ACT_LOW: act_low[1]   <= cfg_data[0];
          REG_TOUCH_EN:     touch_en     <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        now_ms      <= now_ms_next;
        now_p1      <= now_p1_next;
        prev_mask   <= prev_mask_next;
        pin_pressed <= pin_pressed_next;
        change_seen <= change_seen_next;
        long_fired  <= long_fired_next;
        press_time  <= press_time_next;
        last_change <= last_change_next;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/bpc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_queue: event bundle queue
// A short first-in first-out queue of event bundles between the front end
// and the back end.
// ----------------------------------------------------------------------------
module bpc_queue import bpc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             push_ready,
  input  wire bpc_bundle_t push_data,
  output logic             pop_valid,
  input  wire logic        pop,
  output bpc_bundle_t      pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bpc_bundle_t   mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/bpc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_back: event serialiser
// Takes one event bundle at a time from the queue and sends its pending
// events in button order, one result transaction per cycle unless stalled.
// ----------------------------------------------------------------------------
module bpc_back import bpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  wire bpc_bundle_t q_data,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);

  bpc_bundle_t        cur;
  logic [EV_W-1:0]    sel;
  logic [SLOT_W-1:0]  slot;
  logic               has;
  logic               emit;
  logic               src;
  logic [NEVENTS-1:0] rest;
  logic [NEVENTS-1:0] pend_after;

  assign has  = (cur.pend != '0);
  assign emit = has && (!m_tvalid || m_tready);
  assign slot = sel[EV_W-1:1];
  assign src  = (slot >= SLOT_W'(TOUCH_BUTTONS));

  // Lowest pending event goes first.
  always_comb begin
    sel  = '0;
    rest = cur.pend;
    for (int i = NEVENTS - 1; i >= 0; i--) begin
      if (cur.pend[i]) begin
        sel = EV_W'(i);
      end
    end
    rest[sel] = 1'b0;
  end

  assign pend_after = emit ? rest : cur.pend;
  assign q_pop      = q_valid && (pend_after == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      cur.pend <= '0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (q_pop) begin
        cur <= q_data;
      end else begin
        cur.pend <= pend_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tuser        <= cur.kind[sel];
      m_tlast        <= (rest == '0);
      m_tdata[0]     <= src;
      m_tdata[2:1]   <= src ? WHICH_W'(slot - SLOT_W'(TOUCH_BUTTONS)) : WHICH_W'(slot);
      m_tdata[5:3]   <= src ? '0 : cur.mask;
      m_tdata[37:6]  <= cur.dur[slot];
      m_tdata[39:38] <= 2'b00;
    end
  end

endmodule
`default_nettype wire

FILE: design/button_press_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// button_press_classifier: press, release, short and long press events
// Top level: front end, bundle queue and back end serialiser.
// ----------------------------------------------------------------------------
// Use of the block:
// The input stream carries one transaction per input item: a one millisecond
// tick, a touch status mask or a new level on one physical pin; tuser holds
// the command. The output stream carries one transaction per event, with
// tlast set on the final event caused by an input item; an item that causes
// no event gives no output transaction at all.
// The configuration channel writes one register per transaction and is
// always ready; the user must write it only while the block is idle, as
// the block itself does not enforce this. Throughput: the front end takes
// one input transaction per cycle while the queue has room, and the back
// end sends one event per cycle while the receiver is ready; one input
// causes at most six events. The first event of an input is held in turn in
// the queue entry, the back end bundle register and the output register.
// Reset clears all button state, the millisecond counter and the queue, and
// loads the register defaults. When the receiver stalls, the output register
// holds its event, the queue fills and then the input side stops being ready.
// ----------------------------------------------------------------------------
module button_press_classifier import bpc_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // [2:0] touch_bits, [3] read_ok, [4] pin_index, [5] pin_level, [7:6] zero
  input  wire logic [7:0]            s_tdata,
  // [1:0] cmd
  input  wire logic [1:0]            s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [0] source, [2:1] which_button, [5:3] reported_mask, [37:6] hold_ms,
  // [39:38] zero
  output logic [39:0]                m_tdata,
  // [1:0] event_kind
  output logic [1:0]                 m_tuser,
  output logic                       m_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic        push;
  logic        push_ready;
  bpc_bundle_t push_data;
  logic        pop_valid;
  logic        pop;
  bpc_bundle_t pop_data;

  // Front end: state update and classification, one item per cycle if ready.
  bpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_ready   (push_ready),
    .q_push    (push),
    .q_data    (push_data)
  );

  // Only bundles holding at least one event enter the queue.
  bpc_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  // Back end: one event per cycle into the output register unless stalled.
  bpc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (pop_valid),
    .q_pop    (pop),
    .q_data   (pop_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire
